// File: src/jlsp_pkg.sv
package jlsp_pkg;

  // Fixed-point fraction bits of all positions, velocities, accelerations and gains.
  localparam int FRAC_BITS = 8;

  // Field widths.
  localparam int POS_W = 20;
  localparam int VEL_W = 19;
  localparam int ACC_W = 23;
  localparam int MS_W  = 10;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Configuration port address width: eight 32-bit registers.
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_POS_GAIN,
    REG_VEL_GAIN,
    REG_VEL_LIMIT,
    REG_ACC_LIMIT,
    REG_JERK_LIMIT,
    REG_DEF_TICK,
    REG_PULSE_MIN,
    REG_PULSE_MAX
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] position_gain;
    logic [15:0] velocity_gain;
    logic [17:0] velocity_limit;
    logic [21:0] accel_limit;
    logic [23:0] jerk_limit;
    logic [9:0]  default_tick_ms;
    logic [11:0] pulse_min;
    logic [11:0] pulse_max;
  } cfg_t;

endpackage

// File: src/jlsp_in_if.sv
interface jlsp_in_if;
  import jlsp_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] target_pulse;
  logic [MS_W-1:0]  elapsed_ms;

  modport source (output valid, output target_pulse, output elapsed_ms, input ready);
  modport sink   (input valid, input target_pulse, input elapsed_ms, output ready);
endinterface

// File: src/jlsp_out_if.sv
interface jlsp_out_if;
  import jlsp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic        [POS_W-1:0] servo_pulse;
  logic signed [VEL_W-1:0] velocity_now;
  logic signed [ACC_W-1:0] accel_now;

  modport source (output valid, output servo_pulse, output velocity_now, output accel_now,
                  input ready);
  modport sink   (input valid, input servo_pulse, input velocity_now, input accel_now,
                  output ready);
endinterface

// File: src/jlsp_regs.sv
module jlsp_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jlsp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output jlsp_pkg::cfg_t               cfg_o
);
  import jlsp_pkg::*;

  localparam cfg_t CFG_RESET = '{
    position_gain:   16'd512,
    velocity_gain:   16'd1536,
    velocity_limit:  18'd38400,
    accel_limit:     22'd230400,
    jerk_limit:      24'd426752,
    default_tick_ms: 10'd10,
    pulse_min:       12'd800,
    pulse_max:       12'd1800
  };

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_POS_GAIN:   cfg_q.position_gain   <= pwdata[15:0];
        REG_VEL_GAIN:   cfg_q.velocity_gain   <= pwdata[15:0];
        REG_VEL_LIMIT:  cfg_q.velocity_limit  <= pwdata[17:0];
        REG_ACC_LIMIT:  cfg_q.accel_limit     <= pwdata[21:0];
        REG_JERK_LIMIT: cfg_q.jerk_limit      <= pwdata[23:0];
        REG_DEF_TICK:   cfg_q.default_tick_ms <= pwdata[9:0];
        REG_PULSE_MIN:  cfg_q.pulse_min       <= pwdata[11:0];
        REG_PULSE_MAX:  cfg_q.pulse_max       <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POS_GAIN:   prdata = 32'(cfg_q.position_gain);
      REG_VEL_GAIN:   prdata = 32'(cfg_q.velocity_gain);
      REG_VEL_LIMIT:  prdata = 32'(cfg_q.velocity_limit);
      REG_ACC_LIMIT:  prdata = 32'(cfg_q.accel_limit);
      REG_JERK_LIMIT: prdata = 32'(cfg_q.jerk_limit);
      REG_DEF_TICK:   prdata = 32'(cfg_q.default_tick_ms);
      REG_PULSE_MIN:  prdata = 32'(cfg_q.pulse_min);
      REG_PULSE_MAX:  prdata = 32'(cfg_q.pulse_max);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: src/jlsp_mul.sv
module jlsp_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [jlsp_pkg::MUL_W-1:0]   a_i,
  input  logic signed [jlsp_pkg::MUL_W-1:0]   b_i,
  output logic signed [jlsp_pkg::PROD_W-1:0]  prod_o
);
  import jlsp_pkg::*;

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;

  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: src/jlsp_seq.sv
module jlsp_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jlsp_pkg::cfg_t  cfg_i,
  jlsp_in_if.sink         tick_i,
  jlsp_out_if.source      result_o
);
  import jlsp_pkg::*;

  localparam int SW          = 40;
  localparam int LIM_W       = 25;
  localparam int JSTEP_W     = 25;
  localparam int DIV_IN_W    = 31;
  localparam int RECIP_SHIFT = 38;
  // ceil(2^38 / 125); a value shifted right by three and scaled by this gives x / 1000.
  localparam logic [31:0] RECIP_125 = 32'd2199023256;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_M1   = 5'd1;
  localparam logic [4:0] ST_VD   = 5'd2;
  localparam logic [4:0] ST_M2   = 5'd3;
  localparam logic [4:0] ST_AD   = 5'd4;
  localparam logic [4:0] ST_M3   = 5'd5;
  localparam logic [4:0] ST_D3   = 5'd6;
  localparam logic [4:0] ST_J    = 5'd7;
  localparam logic [4:0] ST_DL   = 5'd8;
  localparam logic [4:0] ST_ACC  = 5'd9;
  localparam logic [4:0] ST_M4   = 5'd10;
  localparam logic [4:0] ST_D4   = 5'd11;
  localparam logic [4:0] ST_V    = 5'd12;
  localparam logic [4:0] ST_M5   = 5'd13;
  localparam logic [4:0] ST_D5   = 5'd14;
  localparam logic [4:0] ST_P    = 5'd15;
  localparam logic [4:0] ST_WB   = 5'd16;

  function automatic logic signed [SW-1:0] clamp_sym(input logic signed [SW-1:0] x,
                                                     input logic [LIM_W-1:0] lim);
    logic signed [SW-1:0] l;
    l = $signed({{(SW-LIM_W){1'b0}}, lim});
    if (x < -l) begin
      clamp_sym = -l;
    end else if (x > l) begin
      clamp_sym = l;
    end else begin
      clamp_sym = x;
    end
  endfunction

  // Scale by 2^-FRAC_BITS, truncating toward zero.
  function automatic logic signed [SW-1:0] trunc_frac(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] bias;
    bias = x[SW-1] ? SW'(2**FRAC_BITS - 1) : '0;
    trunc_frac = (x + bias) >>> FRAC_BITS;
  endfunction

  logic [4:0] state_q, state_d;

  logic        [POS_W-1:0]   tgt_q;
  logic        [MS_W-1:0]    ms_q;
  logic signed [VEL_W-1:0]   vd_q;
  logic signed [ACC_W-1:0]   ad_q;
  logic        [JSTEP_W-1:0] jstep_q;
  logic signed [ACC_W:0]     delta_q;
  logic                      neg_q;

  logic        [POS_W-1:0]   pos_q, pos_d;
  logic signed [VEL_W-1:0]   vel_q, vel_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;

  logic                      out_valid_q, out_valid_d;
  logic        [POS_W-1:0]   out_pos_q;
  logic signed [VEL_W-1:0]   out_vel_q;
  logic signed [ACC_W-1:0]   out_acc_q;

  logic                      accept;
  logic                      wb_fire;
  logic                      mul_en;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SW-1:0]      prod_lo;
  logic        [PROD_W-1:0]  mag;
  logic        [JSTEP_W-1:0] quo;
  logic signed [SW-1:0]      quo_s;
  logic signed [POS_W:0]     pos_err;
  logic signed [VEL_W:0]     vel_err;
  logic signed [SW-1:0]      pos_sum, pos_lo, pos_hi, pos_clamped;
  logic signed [SW-1:0]      vd_d, ad_d, delta_d, acc_n, velc_n, vel_n;

  jlsp_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign tick_i.ready = (state_q == ST_IDLE);
  assign accept       = tick_i.valid && tick_i.ready;
  assign wb_fire      = (state_q == ST_WB) && (!out_valid_q || result_o.ready);

  assign prod_lo = prod[SW-1:0];
  assign mag     = prod[PROD_W-1] ? $unsigned(-prod) : $unsigned(prod);
  assign quo     = prod[RECIP_SHIFT+JSTEP_W-1:RECIP_SHIFT];
  assign quo_s   = neg_q ? -$signed({{(SW-JSTEP_W){1'b0}}, quo})
                         :  $signed({{(SW-JSTEP_W){1'b0}}, quo});

  assign pos_err = $signed({1'b0, tgt_q}) - $signed({1'b0, pos_q});
  assign vel_err = (VEL_W+1)'(vd_q) - (VEL_W+1)'(vel_q);

  assign vd_d    = clamp_sym(trunc_frac(prod_lo), LIM_W'(cfg_i.velocity_limit));
  assign ad_d    = clamp_sym(trunc_frac(prod_lo), LIM_W'(cfg_i.accel_limit));
  assign delta_d = clamp_sym(SW'(ad_q) - SW'(acc_q), jstep_q);
  assign acc_n   = clamp_sym(SW'(acc_q) + SW'(delta_q), LIM_W'(cfg_i.accel_limit));
  assign velc_n  = clamp_sym(SW'(vel_q), LIM_W'(cfg_i.velocity_limit));
  assign vel_n   = clamp_sym(SW'(vel_q) + quo_s, LIM_W'(cfg_i.velocity_limit));

  assign pos_sum = $signed({{(SW-POS_W){1'b0}}, pos_q}) + quo_s;
  assign pos_lo  = $signed({{(SW-12-FRAC_BITS){1'b0}}, cfg_i.pulse_min, {FRAC_BITS{1'b0}}});
  assign pos_hi  = $signed({{(SW-12-FRAC_BITS){1'b0}}, cfg_i.pulse_max, {FRAC_BITS{1'b0}}});

  // With inverted limits, a sum below the lower limit gets it, any other the upper.
  always_comb begin
    if (pos_sum < pos_lo) begin
      pos_clamped = pos_lo;
    end else if (pos_sum > pos_hi) begin
      pos_clamped = pos_hi;
    end else begin
      pos_clamped = pos_sum;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      ST_M1: begin
        mul_a = MUL_W'(pos_err);
        mul_b = MUL_W'({1'b0, cfg_i.position_gain});
      end
      ST_M2: begin
        mul_a = MUL_W'(vel_err);
        mul_b = MUL_W'({1'b0, cfg_i.velocity_gain});
      end
      ST_M3: begin
        mul_a = MUL_W'({1'b0, cfg_i.jerk_limit});
        mul_b = MUL_W'({1'b0, ms_q});
      end
      ST_M4: begin
        mul_a = MUL_W'(acc_q);
        mul_b = MUL_W'({1'b0, ms_q});
      end
      ST_M5: begin
        mul_a = MUL_W'(vel_q);
        mul_b = MUL_W'({1'b0, ms_q});
      end
      ST_D3, ST_D4, ST_D5: begin
        mul_a = MUL_W'({1'b0, mag[DIV_IN_W+2:3]});
        mul_b = MUL_W'({1'b0, RECIP_125});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    vel_d   = vel_q;
    acc_d   = acc_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_M1;
      ST_M1:   state_d = ST_VD;
      ST_VD:   state_d = ST_M2;
      ST_M2:   state_d = ST_AD;
      ST_AD:   state_d = ST_M3;
      ST_M3:   state_d = ST_D3;
      ST_D3:   state_d = ST_J;
      ST_J:    state_d = ST_DL;
      ST_DL: begin
        vel_d   = velc_n[VEL_W-1:0];
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d   = acc_n[ACC_W-1:0];
        state_d = ST_M4;
      end
      ST_M4:   state_d = ST_D4;
      ST_D4:   state_d = ST_V;
      ST_V: begin
        vel_d   = vel_n[VEL_W-1:0];
        state_d = ST_M5;
      end
      ST_M5:   state_d = ST_D5;
      ST_D5:   state_d = ST_P;
      ST_P: begin
        pos_d   = pos_clamped[POS_W-1:0];
        state_d = ST_WB;
      end
      ST_WB:   if (wb_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (wb_fire) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      vel_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tgt_q <= tick_i.target_pulse;
      ms_q  <= (tick_i.elapsed_ms == '0) ? cfg_i.default_tick_ms : tick_i.elapsed_ms;
    end
    if (state_q == ST_VD) vd_q <= vd_d[VEL_W-1:0];
    if (state_q == ST_AD) ad_q <= ad_d[ACC_W-1:0];
    if (state_q == ST_J)  jstep_q <= quo;
    if (state_q == ST_DL) delta_q <= delta_d[ACC_W:0];
    if (state_q == ST_D3 || state_q == ST_D4 || state_q == ST_D5) begin
      neg_q <= prod[PROD_W-1];
    end
    if (wb_fire) begin
      out_pos_q <= pos_q;
      out_vel_q <= vel_q;
      out_acc_q <= acc_q;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.servo_pulse  = out_pos_q;
  assign result_o.velocity_now = out_vel_q;
  assign result_o.accel_now    = out_acc_q;

endmodule

// File: src/jerk_limited_servo_profiler.sv
// Jerk-limited servo position profiler.
// Ticks are handled one at a time: the sequencer steps one shared 33x33 multiplier through
// five products and three reciprocal divisions by 1000 before it writes the result and
// takes the next tick; that write waits while an earlier result is still untaken.
// Reset (rst_ni low, asynchronous) clears position, velocity, acceleration and the result
// valid flag, and loads every configuration register with its default.
module jerk_limited_servo_profiler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  jlsp_in_if.sink                      tick_i,
  jlsp_out_if.source                   result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jlsp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import jlsp_pkg::*;

  // APB-style config registers; user must write only while the block is idle; no check.
  cfg_t cfg;

  jlsp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The sequencer takes one tick transaction at a time. It computes the desired velocity
  // and acceleration from the two gain products, limits the change in acceleration by the
  // jerk step, then integrates acceleration, velocity and position with their clamps.
  // Every division by 1000 is a multiply by a reciprocal on the same shared multiplier.
  // The finished result sits in an output register, so a new tick transaction is accepted
  // while the previous result still waits to be taken.
  jlsp_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .tick_i   (tick_i),
    .result_o (result_o)
  );

`ifndef ASSERT_OFF
  // Once a tick transaction is taken the block is busy for the whole sequence.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_i.valid && tick_i.ready) |=> !tick_i.ready)
    else $error("input ready did not drop after a tick transaction");

  // A new result appears only as the sequence ends and the block turns ready again.
  a_result_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> (tick_i.ready && $past(!tick_i.ready)))
    else $error("result appeared outside the end of a sequence");
`endif

endmodule
